/* rtl/skf_pkg.sv */
package skf_pkg;

    // Channel layout: accelerometer axes first, then gyro axes.
    localparam int AXES     = 3;
    localparam int CHANNELS = 2 * AXES;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed-point widths.
    localparam int P_W   = 32;         // covariance and noise, unsigned Q8.24
    localparam int X_W   = 32;         // estimate, signed Q15.16
    localparam int Z_W   = 16;         // sample, signed integer counts
    localparam int FRAC  = 24;         // fraction bits of gain and covariance
    localparam int K_W   = FRAC + 1;   // gain, 0 .. 1.0 in Q1.24
    localparam int KC_W  = $clog2(K_W);
    localparam int D_W   = X_W + 1;    // innovation and its magnitude
    localparam int PX_W  = K_W + D_W;  // gain times innovation magnitude
    localparam int PP_W  = K_W + P_W;  // (1 - gain) times covariance

    localparam logic [K_W-1:0] ONE_Q24 = K_W'(1) << FRAC;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Q  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_R  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_P0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_Q   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_R   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_P0  = 3'd5;

    localparam logic [P_W-1:0] RST_PROC_NOISE  = 32'd167772;
    localparam logic [P_W-1:0] RST_MEAS_NOISE  = 32'd16777216;
    localparam logic [P_W-1:0] RST_INITIAL_COV = 32'd16777216;

    localparam logic MODE_INIT = 1'b0;
    localparam logic KIND_GYRO = 1'b1;

    function automatic logic [P_W-1:0] sat_add(input logic [P_W-1:0] a,
                                               input logic [P_W-1:0] b);
        logic [P_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[P_W] ? {P_W{1'b1}} : sum[P_W-1:0];
    endfunction

endpackage

/* rtl/scalar_kalman_filter_imu.sv */
// Six scalar Kalman filters, one per accelerometer and gyro axis.
// Input channel: in_valid/in_ready with mode, sensor_kind, axis and a signed
// 16-bit measurement. Mode 0 loads the channel's estimate from the sample and
// its covariance from the kind's initial value; mode 1 runs one filter step.
// Output channel: out_valid/out_ready with the channel echo, the new Q15.16
// estimate and the Q1.24 gain used. Every input beat yields one output beat.
// Estimates and covariances live in two small RAMs with registered reads.
// A filter step passes through the read, add, divide, multiply and final
// states, waiting in the divide state on the bit-serial gain divider (25
// quotient bits); a step with a zero denominator skips the divider.
// Initialization and beats on an unused axis go from the read state
// straight to the final state. The next input beat can be taken once the
// previous item has been handed to the output register.
// The result sits in an output register: the next input beat is accepted
// while it waits, and that item only stalls in its final state until out_ready.
// Reset restores the configuration registers to their defaults and marks every
// channel empty (estimate and covariance read as zero until written).
// The configuration port writes a register at any edge with cfg_we high;
// write it only while no item is in flight.
module scalar_kalman_filter_imu (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [skf_pkg::CFG_W-1:0]      cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic                           sensor_kind,
    input  logic [1:0]                     axis,
    input  logic signed [15:0]             measurement,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           sensor_kind_out,
    output logic [1:0]                     axis_out,
    output logic signed [31:0]             estimate,
    output logic [24:0]                    gain
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_ADD1 = 7'b0000100,
        S_ADD2 = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [skf_pkg::P_W-1:0] accel_q_reg, accel_r_reg, accel_p0_reg;
    logic [skf_pkg::P_W-1:0] gyro_q_reg,  gyro_r_reg,  gyro_p0_reg;

    // Item being processed.
    logic                          mode_reg;
    logic                          kind_reg;
    logic [1:0]                    axis_reg;
    logic signed [skf_pkg::Z_W-1:0] z_reg;
    logic [skf_pkg::CH_W-1:0]      ch_reg;
    logic                          axis_ok_reg;

    // Working values.
    logic signed [skf_pkg::X_W-1:0] x_reg;
    logic [skf_pkg::P_W-1:0]        p1_reg;
    logic                           neg_reg;
    logic [skf_pkg::D_W-1:0]        mag_reg;
    logic [skf_pkg::K_W-1:0]        k_reg;
    logic [skf_pkg::PX_W-1:0]       prodx_reg;
    logic [skf_pkg::PP_W-1:0]       prodp_reg;

    logic [skf_pkg::CHANNELS-1:0]   valid_reg, valid_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_kind_reg;
    logic [1:0]                     out_axis_reg;
    logic signed [skf_pkg::X_W-1:0] out_est_reg;
    logic [skf_pkg::K_W-1:0]        out_gain_reg;

    logic                           in_fire;
    logic                           emit;
    logic [skf_pkg::CH_W-1:0]       ch_in;
    logic                           axis_ok_in;

    logic [skf_pkg::P_W-1:0]        q_sel, r_sel, p0_sel;
    logic [skf_pkg::X_W-1:0]        est_rdata;
    logic [skf_pkg::P_W-1:0]        cov_rdata;
    logic signed [skf_pkg::X_W-1:0] x_cur;
    logic [skf_pkg::P_W-1:0]        p_cur;
    logic signed [skf_pkg::X_W-1:0] zf;
    logic signed [skf_pkg::D_W-1:0] innov;
    logic [skf_pkg::P_W-1:0]        s_sum;

    logic                           div_start;
    logic                           div_done;
    logic [skf_pkg::K_W-1:0]        div_quot;

    logic [skf_pkg::X_W+1:0]        dm;
    logic signed [skf_pkg::X_W+3:0] nx_wide;
    logic signed [skf_pkg::X_W-1:0] nx;
    logic [skf_pkg::P_W-1:0]        p_new;
    logic signed [skf_pkg::X_W-1:0] est_new;
    logic [skf_pkg::P_W-1:0]        cov_new;
    logic                           ram_we;

    localparam logic signed [skf_pkg::X_W+3:0] X_MAX = (skf_pkg::X_W + 4)'(32'sh7FFFFFFF);
    localparam logic signed [skf_pkg::X_W+3:0] X_MIN =
        -(skf_pkg::X_W + 4)'(64'sh80000000);

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign emit     = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign axis_ok_in = (int'(axis) < skf_pkg::AXES);
    assign ch_in = sensor_kind ? skf_pkg::CH_W'(skf_pkg::AXES) + skf_pkg::CH_W'(axis)
                               : skf_pkg::CH_W'(axis);

    assign q_sel  = (kind_reg == skf_pkg::KIND_GYRO) ? gyro_q_reg  : accel_q_reg;
    assign r_sel  = (kind_reg == skf_pkg::KIND_GYRO) ? gyro_r_reg  : accel_r_reg;
    assign p0_sel = (kind_reg == skf_pkg::KIND_GYRO) ? gyro_p0_reg : accel_p0_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_q_reg  <= skf_pkg::RST_PROC_NOISE;
            accel_r_reg  <= skf_pkg::RST_MEAS_NOISE;
            accel_p0_reg <= skf_pkg::RST_INITIAL_COV;
            gyro_q_reg   <= skf_pkg::RST_PROC_NOISE;
            gyro_r_reg   <= skf_pkg::RST_MEAS_NOISE;
            gyro_p0_reg  <= skf_pkg::RST_INITIAL_COV;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                skf_pkg::REG_ACCEL_Q:  accel_q_reg  <= cfg_data;
                skf_pkg::REG_ACCEL_R:  accel_r_reg  <= cfg_data;
                skf_pkg::REG_ACCEL_P0: accel_p0_reg <= cfg_data;
                skf_pkg::REG_GYRO_Q:   gyro_q_reg   <= cfg_data;
                skf_pkg::REG_GYRO_R:   gyro_r_reg   <= cfg_data;
                skf_pkg::REG_GYRO_P0:  gyro_p0_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // State memories: one entry per channel, addressed by the held channel.
    skf_ram #(
        .WIDTH (skf_pkg::X_W),
        .DEPTH (skf_pkg::CHANNELS)
    ) u_est_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (est_new),
        .raddr (ch_reg),
        .rdata (est_rdata)
    );

    skf_ram #(
        .WIDTH (skf_pkg::P_W),
        .DEPTH (skf_pkg::CHANNELS)
    ) u_cov_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (cov_new),
        .raddr (ch_reg),
        .rdata (cov_rdata)
    );

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (p1_reg),
        .denom (s_sum),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Read-side arithmetic. A channel never written reads as zero.
    always_comb
    begin
        x_cur = valid_reg[ch_reg] ? $signed(est_rdata) : '0;
        p_cur = valid_reg[ch_reg] ? cov_rdata : '0;
        zf    = $signed({z_reg, 16'b0});
        innov = skf_pkg::D_W'(zf) - skf_pkg::D_W'(x_cur);
        s_sum = skf_pkg::sat_add(p1_reg, r_sel);
        div_start = (state_reg == S_ADD2) && (s_sum != '0);
    end

    // Write-back arithmetic.
    always_comb
    begin
        dm      = prodx_reg[skf_pkg::PX_W-1:skf_pkg::FRAC];
        nx_wide = neg_reg ? (skf_pkg::X_W + 4)'(x_reg) - $signed({2'b00, dm})
                          : (skf_pkg::X_W + 4)'(x_reg) + $signed({2'b00, dm});
        if (nx_wide > X_MAX)
        begin
            nx = X_MAX[skf_pkg::X_W-1:0];
        end
        else if (nx_wide < X_MIN)
        begin
            nx = X_MIN[skf_pkg::X_W-1:0];
        end
        else
        begin
            nx = nx_wide[skf_pkg::X_W-1:0];
        end
        p_new = prodp_reg[skf_pkg::P_W+skf_pkg::FRAC-1:skf_pkg::FRAC];

        if (mode_reg == skf_pkg::MODE_INIT)
        begin
            est_new = zf;
            cov_new = p0_sel;
        end
        else
        begin
            est_new = nx;
            cov_new = p_new;
        end
        ram_we = emit && axis_ok_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if ((mode_reg == skf_pkg::MODE_INIT) || !axis_ok_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_ADD1;
                end
            end
            S_ADD1:
            begin
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                state_next = div_start ? S_DIV : S_MUL;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ch_reg] = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= mode;
            kind_reg    <= sensor_kind;
            axis_reg    <= axis;
            z_reg       <= measurement;
            ch_reg      <= ch_in;
            axis_ok_reg <= axis_ok_in;
            k_reg       <= '0;
        end

        if (state_reg == S_ADD1)
        begin
            x_reg   <= x_cur;
            p1_reg  <= skf_pkg::sat_add(p_cur, q_sel);
            neg_reg <= innov[skf_pkg::D_W-1];
            mag_reg <= innov[skf_pkg::D_W-1] ? skf_pkg::D_W'(-innov) : skf_pkg::D_W'(innov);
        end

        if ((state_reg == S_DIV) && div_done)
        begin
            k_reg <= div_quot;
        end

        if (state_reg == S_MUL)
        begin
            prodx_reg <= skf_pkg::PX_W'(k_reg) * skf_pkg::PX_W'(mag_reg);
            prodp_reg <= skf_pkg::PP_W'(skf_pkg::ONE_Q24 - k_reg) * skf_pkg::PP_W'(p1_reg);
        end

        if (emit)
        begin
            out_kind_reg <= kind_reg;
            out_axis_reg <= axis_reg;
            out_est_reg  <= axis_ok_reg ? est_new : '0;
            out_gain_reg <= k_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sensor_kind_out = out_kind_reg;
    assign axis_out        = out_axis_reg;
    assign estimate        = out_est_reg;
    assign gain            = out_gain_reg;

endmodule

/* rtl/skf_ram.sv */
module skf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/skf_div.sv */
module skf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [skf_pkg::P_W-1:0]   numer,
    input  logic [skf_pkg::P_W-1:0]   denom,
    output logic                      done,
    output logic [skf_pkg::K_W-1:0]   quot
);

    // Restoring division of numer * 2^24 by denom, one quotient bit a cycle.
    // numer never exceeds denom, so the quotient fits in 25 bits and the
    // partial remainder always stays below denom.

    logic [skf_pkg::P_W-1:0]  rem_reg,  rem_next;
    logic [skf_pkg::P_W-1:0]  den_reg,  den_next;
    logic [skf_pkg::K_W-1:0]  quo_reg,  quo_next;
    logic [skf_pkg::KC_W-1:0] cnt_reg,  cnt_next;
    logic                     lsb_reg,  lsb_next;
    logic                     run_reg,  run_next;
    logic                     done_reg, done_next;

    logic [skf_pkg::P_W:0]    shifted;
    logic [skf_pkg::P_W+1:0]  trial;
    logic                     qbit;

    always_comb
    begin
        // Only the top step shifts in a dividend bit; the rest are zeros.
        shifted = {rem_reg, (cnt_reg == skf_pkg::KC_W'(skf_pkg::K_W - 1)) ? lsb_reg : 1'b0};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        qbit    = !trial[skf_pkg::P_W+1];

        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        lsb_next  = lsb_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = numer >> 1;
            lsb_next = numer[0];
            den_next = denom;
            quo_next = '0;
            cnt_next = skf_pkg::KC_W'(skf_pkg::K_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = qbit ? trial[skf_pkg::P_W-1:0] : shifted[skf_pkg::P_W-1:0];
            quo_next = {quo_reg[skf_pkg::K_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        lsb_reg <= lsb_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
